// ----- hdl/tga_rle_pkg.sv -----
`timescale 1ns / 1ps

package tga_rle_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] REG_RLE_MODE    = 3'd0;
    localparam logic [2:0] REG_COLOR_BITS  = 3'd1;
    localparam logic [2:0] REG_PIXEL_BYTES = 3'd2;
    localparam logic [2:0] REG_DATA_LENGTH = 3'd3;
    localparam logic [2:0] REG_PIXEL_LIMIT = 3'd4;

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_PIXEL  = 2'd1;
    localparam logic [1:0] PH_STOP   = 2'd2;

    localparam logic [5:0] TRUE_COLOR_BITS = 6'd24;
    localparam logic [7:0] ALPHA_OPAQUE    = 8'd255;

    // x * 255 / 31 for a five-bit channel
    localparam logic [7:0] EXPAND5 [32] = '{
        8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
        8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
        8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
        8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
    };

    typedef struct packed {
        logic        rle_mode;
        logic [5:0]  color_bits;
        logic [2:0]  pixel_bytes;
        logic [31:0] data_length;
        logic [31:0] pixel_limit;
    } cfg_t;

    typedef struct packed {
        logic        trunc;
        logic [31:0] word;
        logic [31:0] start;
        logic [7:0]  rep;
    } job_t;

endpackage

// ----- hdl/tga_rle_front.sv -----
`timescale 1ns / 1ps

module tga_rle_front
    import tga_rle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       in_valid,
    input  logic [7:0] in_byte,
    input  logic       room,
    output logic       in_ready,
    output logic       push,
    output job_t       push_job
);

    logic [1:0]  phase_reg, phase_next;
    logic [7:0]  packet_left_reg, packet_left_next;
    logic        is_run_reg, is_run_next;
    logic [1:0]  bip_reg, bip_next;
    logic [31:0] asm_reg, asm_next;
    logic [31:0] pix_cnt_reg, pix_cnt_next;
    logic [31:0] byte_cnt_reg, byte_cnt_next;

    logic        accept;
    logic [2:0]  stride;
    logic        pix_done;
    logic [31:0] asm_or;
    logic [31:0] byte_inc;
    logic [7:0]  count;
    logic [9:0]  lit_need;
    logic [9:0]  need;
    logic        over;
    logic        at_end;
    logic [7:0]  rep;
    logic [32:0] pix_sum;
    logic [31:0] pix_add;

    assign in_ready = room;
    assign accept   = in_valid && room;

    always_comb
    begin
        if (cfg.pixel_bytes < 3'd2)
        begin
            stride = 3'd2;
        end
        else if (cfg.pixel_bytes > 3'd4)
        begin
            stride = 3'd4;
        end
        else
        begin
            stride = cfg.pixel_bytes;
        end
    end

    assign pix_done = ({1'b0, bip_reg} + 3'd1) >= stride;
    assign asm_or   = asm_reg | ({24'd0, in_byte} << {bip_reg, 3'b000});
    assign byte_inc = (byte_cnt_reg == 32'hFFFF_FFFF) ? byte_cnt_reg : byte_cnt_reg + 32'd1;
    assign count    = {1'b0, in_byte[6:0]} + 8'd1;
    assign lit_need = {2'd0, count} * {7'd0, stride};
    assign need     = in_byte[7] ? {7'd0, stride} : lit_need;
    assign over     = ({1'b0, byte_inc} + {23'd0, need}) > {1'b0, cfg.data_length};
    assign at_end   = byte_cnt_reg >= cfg.data_length;

    assign rep      = (cfg.rle_mode && is_run_reg) ? packet_left_reg : 8'd1;
    assign pix_sum  = {1'b0, pix_cnt_reg} + {25'd0, rep};
    assign pix_add  = pix_sum[32] ? 32'hFFFF_FFFF : pix_sum[31:0];

    always_comb
    begin
        phase_next       = phase_reg;
        packet_left_next = packet_left_reg;
        is_run_next      = is_run_reg;
        bip_next         = bip_reg;
        asm_next         = asm_reg;
        pix_cnt_next     = pix_cnt_reg;
        byte_cnt_next    = byte_cnt_reg;
        push             = 1'b0;
        push_job.trunc   = 1'b0;
        push_job.word    = asm_or;
        push_job.start   = pix_cnt_reg;
        push_job.rep     = rep;

        priority if (!accept || phase_reg >= PH_STOP)
        begin
            phase_next = phase_reg;
        end
        else if (!cfg.rle_mode || phase_reg == PH_PIXEL)
        begin
            byte_cnt_next = byte_inc;
            if (pix_done)
            begin
                push         = 1'b1;
                pix_cnt_next = pix_add;
                bip_next     = 2'd0;
                asm_next     = 32'd0;
                if (cfg.rle_mode)
                begin
                    if (is_run_reg || packet_left_reg == 8'd0 || packet_left_reg == 8'd1)
                    begin
                        packet_left_next = 8'd0;
                        phase_next       = PH_HEADER;
                    end
                    else
                    begin
                        packet_left_next = packet_left_reg - 8'd1;
                    end
                end
            end
            else
            begin
                bip_next = bip_reg + 2'd1;
                asm_next = asm_or;
            end
        end
        else if (!at_end)
        begin
            byte_cnt_next = byte_inc;
            is_run_next   = in_byte[7];
            if (over)
            begin
                phase_next     = PH_STOP;
                push           = 1'b1;
                push_job.trunc = 1'b1;
                push_job.word  = 32'd0;
                push_job.rep   = 8'd0;
            end
            else
            begin
                phase_next       = PH_PIXEL;
                packet_left_next = count;
                bip_next         = 2'd0;
                asm_next         = 32'd0;
            end
        end
        else
        begin
            // drop a header that arrives with no data left
            phase_next = phase_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HEADER;
            packet_left_reg <= 8'd0;
            is_run_reg      <= 1'b0;
            bip_reg         <= 2'd0;
            asm_reg         <= 32'd0;
            pix_cnt_reg     <= 32'd0;
            byte_cnt_reg    <= 32'd0;
        end
        else
        begin
            phase_reg       <= phase_next;
            packet_left_reg <= packet_left_next;
            is_run_reg      <= is_run_next;
            bip_reg         <= bip_next;
            asm_reg         <= asm_next;
            pix_cnt_reg     <= pix_cnt_next;
            byte_cnt_reg    <= byte_cnt_next;
        end
    end

endmodule

// ----- hdl/tga_rle_queue.sv -----
`timescale 1ns / 1ps

module tga_rle_queue
    import tga_rle_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t head,
    output logic full,
    output logic empty
);

    job_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full    = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ----- hdl/tga_rle_back.sv -----
`timescale 1ns / 1ps

module tga_rle_back
    import tga_rle_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  job_t        head,
    input  logic        empty,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic [7:0]  alpha,
    output logic [31:0] start_pixel,
    output logic [7:0]  repeat_count,
    output logic        truncated
);

    logic        valid_reg, valid_next;
    logic [7:0]  red_reg, green_reg, blue_reg, alpha_reg, rep_reg;
    logic [31:0] start_reg;
    logic        trunc_reg;

    logic        load;
    logic        past_limit;
    logic [31:0] avail;
    logic [7:0]  n;
    logic        keep;
    logic [7:0]  r, g, b, a;

    assign load       = !valid_reg || out_ready;
    assign pop        = load && !empty;
    assign past_limit = head.start >= cfg.pixel_limit;
    assign avail      = cfg.pixel_limit - head.start;
    assign n          = ({24'd0, head.rep} < avail) ? head.rep : avail[7:0];
    assign keep       = head.trunc || (!past_limit && n != 8'd0);

    always_comb
    begin
        a = ALPHA_OPAQUE;
        if (head.trunc)
        begin
            r = 8'd0;
            g = 8'd0;
            b = 8'd0;
            a = 8'd0;
        end
        else if (cfg.color_bits >= TRUE_COLOR_BITS)
        begin
            r = head.word[23:16];
            g = head.word[15:8];
            b = head.word[7:0];
            if (cfg.color_bits > TRUE_COLOR_BITS)
            begin
                a = head.word[31:24];
            end
        end
        else
        begin
            r = EXPAND5[head.word[14:10]];
            g = EXPAND5[head.word[9:5]];
            b = EXPAND5[head.word[4:0]];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = pop && keep;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            red_reg   <= r;
            green_reg <= g;
            blue_reg  <= b;
            alpha_reg <= a;
            start_reg <= head.start;
            rep_reg   <= head.trunc ? 8'd0 : n;
            trunc_reg <= head.trunc;
        end
    end

    assign out_valid    = valid_reg;
    assign red          = red_reg;
    assign green        = green_reg;
    assign blue         = blue_reg;
    assign alpha        = alpha_reg;
    assign start_pixel  = start_reg;
    assign repeat_count = rep_reg;
    assign truncated    = trunc_reg;

endmodule

// ----- hdl/tga_rle_truecolor_decoder.sv -----
`timescale 1ns / 1ps

// TGA true-color image data decoder, run-length or raw, one data byte per item on the
// slave stream. The parser takes one byte every cycle whenever its two-entry result
// queue has room, so a steady stream moves at one byte per clock; each finished pixel
// or run leaves through a registered master stage, at most one result per clock, and
// the queue absorbs short stalls on the master side. A run comes out as a single
// result with a repeat count, clipped at pixel_limit; results at or past the limit
// are dropped. A packet that would overrun data_length yields one result with tuser set
// and stops decoding until reset. Configuration registers (index 0 rle_mode, 1 color_bits,
// 2 pixel_bytes, 3 data_length, 4 pixel_limit) must be written only while no item is in
// flight (not enforced); writes do not reset the parser. No startup sweep is needed.

module tga_rle_truecolor_decoder
    import tga_rle_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,    // [7:0] red, [15:8] green, [23:16] blue,
                                    // [31:24] alpha, [63:32] start_pixel,
                                    // [71:64] repeat_count
    output logic [0:0]  m_tuser,    // [0] truncated

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    cfg_t cfg_reg;

    logic q_full;
    logic q_empty;
    logic push;
    job_t push_job;
    logic pop;
    job_t head;

    logic [7:0]  red, green, blue, alpha, repeat_count;
    logic [31:0] start_pixel;
    logic        truncated;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rle_mode    <= 1'b1;
            cfg_reg.color_bits  <= TRUE_COLOR_BITS;
            cfg_reg.pixel_bytes <= 3'd3;
            cfg_reg.data_length <= 32'd0;
            cfg_reg.pixel_limit <= 32'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_RLE_MODE:    cfg_reg.rle_mode    <= cfg_data[0];
                REG_COLOR_BITS:  cfg_reg.color_bits  <= cfg_data[5:0];
                REG_PIXEL_BYTES: cfg_reg.pixel_bytes <= cfg_data[2:0];
                REG_DATA_LENGTH: cfg_reg.data_length <= cfg_data;
                REG_PIXEL_LIMIT: cfg_reg.pixel_limit <= cfg_data;
                default:         cfg_reg.rle_mode    <= cfg_reg.rle_mode;
            endcase
        end
    end

    tga_rle_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (s_tvalid),
        .in_byte  (s_tdata),
        .room     (!q_full),
        .in_ready (s_tready),
        .push     (push),
        .push_job (push_job)
    );

    tga_rle_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .full     (q_full),
        .empty    (q_empty)
    );

    tga_rle_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .head         (head),
        .empty        (q_empty),
        .pop          (pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .alpha        (alpha),
        .start_pixel  (start_pixel),
        .repeat_count (repeat_count),
        .truncated    (truncated)
    );

    assign m_tdata    = {repeat_count, start_pixel, alpha, blue, green, red};
    assign m_tuser[0] = truncated;

    a_trunc_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tuser[0] |=> !m_tvalid)
        else $error("result after truncation");

    a_trunc_clear: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[71:64] == 8'd0 && m_tdata[31:0] == 32'd0)
        else $error("truncation result carries pixel data");

    a_pixel_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[71:64] != 8'd0 && m_tdata[71:64] <= 8'd128)
        else $error("pixel result with bad repeat count");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !s_tready && !push)
        else $error("push into full queue");

endmodule
